// ===== rtl/cabac_pkg.sv =====
`default_nettype none

package cabac_pkg;

    typedef enum logic [2:0] {
        CMD_START_FIRST  = 3'd0,
        CMD_START_SECOND = 3'd1,
        CMD_CTX_BIN      = 3'd2,
        CMD_BYPASS       = 3'd3,
        CMD_TERMINATE    = 3'd4,
        CMD_LOAD_CTX     = 3'd5
    } cmd_t;

    localparam logic [8:0]  RANGE_INIT = 9'd510;
    localparam logic [4:0]  BW_INIT    = 5'd8;
    localparam logic [4:0]  BW_REFILL  = 5'b11000;
    localparam logic [4:0]  BYTE_BITS  = 5'd8;
    localparam logic [8:0]  TERM_LPS   = 9'd2;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] stream_byte;
        logic       stream_byte_valid;
        logic [5:0] load_prob_state;
        logic       load_mps;
    } item_t;

    typedef struct packed {
        logic [8:0]  coder_range;
        logic [16:0] coder_offset;
        logic [4:0]  bits_wanted;
    } coder_t;

    typedef struct packed {
        coder_t     coder;
        logic       bin_value;
        logic       byte_taken;
        logic [5:0] new_prob_state;
        logic       new_mps;
        logic       ctx_we;
    } upd_t;

    localparam logic [0:63][0:3][7:0] LPS_TAB = {
        {8'd128, 8'd176, 8'd208, 8'd240}, {8'd128, 8'd167, 8'd197, 8'd227},
        {8'd128, 8'd158, 8'd187, 8'd216}, {8'd123, 8'd150, 8'd178, 8'd205},
        {8'd116, 8'd142, 8'd169, 8'd195}, {8'd111, 8'd135, 8'd160, 8'd185},
        {8'd105, 8'd128, 8'd152, 8'd175}, {8'd100, 8'd122, 8'd144, 8'd166},
        {8'd95,  8'd116, 8'd137, 8'd158}, {8'd90,  8'd110, 8'd130, 8'd150},
        {8'd85,  8'd104, 8'd123, 8'd142}, {8'd81,  8'd99,  8'd117, 8'd135},
        {8'd77,  8'd94,  8'd111, 8'd128}, {8'd73,  8'd89,  8'd105, 8'd122},
        {8'd69,  8'd85,  8'd100, 8'd116}, {8'd66,  8'd80,  8'd95,  8'd110},
        {8'd62,  8'd76,  8'd90,  8'd104}, {8'd59,  8'd72,  8'd86,  8'd99},
        {8'd56,  8'd69,  8'd81,  8'd94},  {8'd53,  8'd65,  8'd77,  8'd89},
        {8'd51,  8'd62,  8'd73,  8'd85},  {8'd48,  8'd59,  8'd69,  8'd80},
        {8'd46,  8'd56,  8'd66,  8'd76},  {8'd43,  8'd53,  8'd63,  8'd72},
        {8'd41,  8'd50,  8'd59,  8'd69},  {8'd39,  8'd48,  8'd56,  8'd65},
        {8'd37,  8'd45,  8'd54,  8'd62},  {8'd35,  8'd43,  8'd51,  8'd59},
        {8'd33,  8'd41,  8'd48,  8'd56},  {8'd32,  8'd39,  8'd46,  8'd53},
        {8'd30,  8'd37,  8'd43,  8'd50},  {8'd29,  8'd35,  8'd41,  8'd48},
        {8'd27,  8'd33,  8'd39,  8'd45},  {8'd26,  8'd31,  8'd37,  8'd43},
        {8'd24,  8'd30,  8'd35,  8'd41},  {8'd23,  8'd28,  8'd33,  8'd39},
        {8'd22,  8'd27,  8'd32,  8'd37},  {8'd21,  8'd26,  8'd30,  8'd35},
        {8'd20,  8'd24,  8'd29,  8'd33},  {8'd19,  8'd23,  8'd27,  8'd31},
        {8'd18,  8'd22,  8'd26,  8'd30},  {8'd17,  8'd21,  8'd25,  8'd28},
        {8'd16,  8'd20,  8'd23,  8'd27},  {8'd15,  8'd19,  8'd22,  8'd25},
        {8'd14,  8'd18,  8'd21,  8'd24},  {8'd14,  8'd17,  8'd20,  8'd23},
        {8'd13,  8'd16,  8'd19,  8'd22},  {8'd12,  8'd15,  8'd18,  8'd21},
        {8'd12,  8'd14,  8'd17,  8'd20},  {8'd11,  8'd14,  8'd16,  8'd19},
        {8'd11,  8'd13,  8'd15,  8'd18},  {8'd10,  8'd12,  8'd15,  8'd17},
        {8'd10,  8'd12,  8'd14,  8'd16},  {8'd9,   8'd11,  8'd13,  8'd15},
        {8'd9,   8'd11,  8'd12,  8'd14},  {8'd8,   8'd10,  8'd12,  8'd14},
        {8'd8,   8'd9,   8'd11,  8'd13},  {8'd7,   8'd9,   8'd11,  8'd12},
        {8'd7,   8'd9,   8'd10,  8'd12},  {8'd7,   8'd8,   8'd10,  8'd11},
        {8'd6,   8'd8,   8'd9,   8'd11},  {8'd6,   8'd7,   8'd9,   8'd10},
        {8'd6,   8'd7,   8'd8,   8'd9},   {8'd2,   8'd2,   8'd2,   8'd2}
    };

    localparam logic [0:63][5:0] NEXT_LPS = {
        6'd0,  6'd0,  6'd1,  6'd2,  6'd2,  6'd4,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd9,  6'd11, 6'd11, 6'd12,
        6'd13, 6'd13, 6'd15, 6'd15, 6'd16, 6'd16, 6'd18, 6'd18,
        6'd19, 6'd19, 6'd21, 6'd21, 6'd22, 6'd22, 6'd23, 6'd24,
        6'd24, 6'd25, 6'd26, 6'd26, 6'd27, 6'd27, 6'd28, 6'd29,
        6'd29, 6'd30, 6'd30, 6'd30, 6'd31, 6'd32, 6'd32, 6'd33,
        6'd33, 6'd33, 6'd34, 6'd34, 6'd35, 6'd35, 6'd35, 6'd36,
        6'd36, 6'd36, 6'd37, 6'd37, 6'd37, 6'd38, 6'd38, 6'd63
    };

    function automatic logic [5:0] next_mps(input logic [5:0] st);
        logic [5:0] nxt;
        nxt = (st >= 6'd62) ? st : st + 6'd1;
        return nxt;
    endfunction

    function automatic logic [3:0] lps_shift(input logic [7:0] lps);
        logic [3:0] sh;
        priority casez (lps)
            8'b1???????: sh = 4'd1;
            8'b01??????: sh = 4'd2;
            8'b001?????: sh = 4'd3;
            8'b0001????: sh = 4'd4;
            8'b00001???: sh = 4'd5;
            8'b000001??: sh = 4'd6;
            8'b0000001?: sh = 4'd7;
            default:     sh = 4'd8;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cabac_if.sv =====
`default_nettype none

interface cabac_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [8:0] ctx_index;
    logic [7:0] stream_byte;
    logic       stream_byte_valid;
    logic [5:0] load_prob_state;
    logic       load_mps;

    modport source (
        output valid, cmd, ctx_index, stream_byte, stream_byte_valid,
               load_prob_state, load_mps,
        input  ready
    );
    modport sink (
        input  valid, cmd, ctx_index, stream_byte, stream_byte_valid,
               load_prob_state, load_mps,
        output ready
    );
endinterface

interface cabac_result_if;
    logic       valid;
    logic       ready;
    logic       bin_value;
    logic       byte_taken;
    logic [5:0] new_prob_state;
    logic       new_mps;

    modport source (
        output valid, bin_value, byte_taken, new_prob_state, new_mps,
        input  ready
    );
    modport sink (
        input  valid, bin_value, byte_taken, new_prob_state, new_mps,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/cabac_ram.sv =====
`default_nettype none

module cabac_ram #(
    parameter int WIDTH  = 7,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cabac_bin_core.sv =====
`default_nettype none

module cabac_bin_core (
    input  wire cabac_pkg::coder_t cur,
    input  wire cabac_pkg::item_t  it,
    input  wire logic [6:0]        ctx_word,
    output cabac_pkg::upd_t        upd
);

    logic [5:0]  st;
    logic        mps;
    logic [7:0]  lps;
    logic [8:0]  rmps;
    logic [15:0] scaled;
    logic [3:0]  shift;
    logic [16:0] off_sub;
    logic [4:0]  bw_lps;
    logic [4:0]  bw_inc;
    logic [22:0] ins;
    logic [8:0]  rterm;
    logic [15:0] sc_term;
    logic [15:0] sc_byp;
    logic [16:0] off_byp;

    always_comb
    begin
        st      = ctx_word[5:0];
        mps     = ctx_word[6];
        lps     = cabac_pkg::LPS_TAB[st][cur.coder_range[7:6]];
        rmps    = cur.coder_range - {1'b0, lps};
        scaled  = {rmps, 7'd0};
        shift   = cabac_pkg::lps_shift(lps);
        off_sub = cur.coder_offset - {1'b0, scaled};
        bw_lps  = cur.bits_wanted + {1'b0, shift};
        bw_inc  = cur.bits_wanted + 5'd1;
        ins     = {15'd0, it.stream_byte} << bw_lps[3:0];
        rterm   = cur.coder_range - cabac_pkg::TERM_LPS;
        sc_term = {rterm, 7'd0};
        sc_byp  = {cur.coder_range, 7'd0};
        off_byp = {cur.coder_offset[15:0], 1'b0};
        if (!bw_inc[4] && it.stream_byte_valid)
        begin
            off_byp = off_byp | {9'd0, it.stream_byte};
        end
    end

    always_comb
    begin
        upd       = '0;
        upd.coder = cur;
        unique case (cabac_pkg::cmd_t'(it.cmd))
            cabac_pkg::CMD_START_FIRST:
            begin
                upd.coder.coder_range = cabac_pkg::RANGE_INIT;
                if (it.stream_byte_valid)
                begin
                    upd.coder.coder_offset = {1'b0, it.stream_byte, 8'd0};
                    upd.coder.bits_wanted  = '0;
                    upd.byte_taken         = 1'b1;
                end
                else
                begin
                    upd.coder.coder_offset = '0;
                    upd.coder.bits_wanted  = cabac_pkg::BW_INIT;
                end
            end
            cabac_pkg::CMD_START_SECOND:
            begin
                if (it.stream_byte_valid)
                begin
                    upd.coder.coder_offset = cur.coder_offset | {9'd0, it.stream_byte};
                    upd.coder.bits_wanted  = cur.bits_wanted - cabac_pkg::BYTE_BITS;
                    upd.byte_taken         = 1'b1;
                end
            end
            cabac_pkg::CMD_CTX_BIN:
            begin
                upd.ctx_we = 1'b1;
                if (cur.coder_offset < {1'b0, scaled})
                begin
                    upd.bin_value         = mps;
                    upd.new_prob_state    = cabac_pkg::next_mps(st);
                    upd.new_mps           = mps;
                    upd.coder.coder_range = rmps;
                    if (!rmps[8])
                    begin
                        upd.coder.coder_range  = {rmps[7:0], 1'b0};
                        upd.coder.coder_offset = {cur.coder_offset[15:0], 1'b0};
                        upd.coder.bits_wanted  = bw_inc;
                        if (bw_inc == 5'd0)
                        begin
                            upd.coder.bits_wanted = cabac_pkg::BW_REFILL;
                            if (it.stream_byte_valid)
                            begin
                                upd.coder.coder_offset = {cur.coder_offset[15:0], 1'b0}
                                                       | {9'd0, it.stream_byte};
                                upd.byte_taken         = 1'b1;
                            end
                        end
                    end
                end
                else
                begin
                    upd.bin_value          = ~mps;
                    upd.new_prob_state     = cabac_pkg::NEXT_LPS[st];
                    upd.new_mps            = (st == 6'd0) ? ~mps : mps;
                    upd.coder.coder_range  = 9'({1'b0, lps} << shift);
                    upd.coder.coder_offset = off_sub << shift;
                    upd.coder.bits_wanted  = bw_lps;
                    if (!bw_lps[4])
                    begin
                        if (it.stream_byte_valid)
                        begin
                            upd.coder.coder_offset = (off_sub << shift) | ins[16:0];
                            upd.byte_taken         = 1'b1;
                        end
                        upd.coder.bits_wanted = bw_lps - cabac_pkg::BYTE_BITS;
                    end
                end
            end
            cabac_pkg::CMD_BYPASS:
            begin
                upd.coder.bits_wanted = bw_inc[4] ? bw_inc : cabac_pkg::BW_REFILL;
                upd.byte_taken        = !bw_inc[4] && it.stream_byte_valid;
                if (off_byp >= {1'b0, sc_byp})
                begin
                    upd.coder.coder_offset = off_byp - {1'b0, sc_byp};
                    upd.bin_value          = 1'b1;
                end
                else
                begin
                    upd.coder.coder_offset = off_byp;
                end
            end
            cabac_pkg::CMD_TERMINATE:
            begin
                upd.coder.coder_range = rterm;
                if (cur.coder_offset >= {1'b0, sc_term})
                begin
                    upd.bin_value = 1'b1;
                end
                else if (!rterm[8])
                begin
                    upd.coder.coder_range  = {rterm[7:0], 1'b0};
                    upd.coder.coder_offset = {cur.coder_offset[15:0], 1'b0};
                    upd.coder.bits_wanted  = bw_inc;
                    if (bw_inc == 5'd0)
                    begin
                        upd.coder.bits_wanted = cabac_pkg::BW_REFILL;
                        if (it.stream_byte_valid)
                        begin
                            upd.coder.coder_offset = {cur.coder_offset[15:0], 1'b0}
                                                   | {9'd0, it.stream_byte};
                            upd.byte_taken         = 1'b1;
                        end
                    end
                end
            end
            cabac_pkg::CMD_LOAD_CTX:
            begin
                upd.ctx_we         = 1'b1;
                upd.new_prob_state = it.load_prob_state;
                upd.new_mps        = it.load_mps;
            end
            default:
            begin
                upd.coder = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/cabac_arithmetic_decoder.sv =====
// Stages: an accepted input word is registered together with its context memory read,
// then its result word is registered at the output. Throughput: one word per cycle
// while the output is not stalled; the coder state loops through the combinational
// bin unit. Reset: range 510, offset 0, bits wanted 8; context entries are undefined
// until loaded and get no clearing pass, so words are accepted right after reset.
`default_nettype none

module cabac_arithmetic_decoder #(
    parameter int NUM_CONTEXTS = 512
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    cabac_item_if.sink     item,
    cabac_result_if.source result
);

    localparam int CTX_AW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

    function automatic logic [CTX_AW-1:0] ctx_fold(input logic [8:0] idx);
        logic [8:0] r;
        r = idx;
        for (int k = 8; k >= 0; k--)
        begin
            if ((NUM_CONTEXTS << k) <= 511)
            begin
                if (32'(r) >= 32'(NUM_CONTEXTS << k))
                begin
                    r = r - 9'(NUM_CONTEXTS << k);
                end
            end
        end
        return CTX_AW'(r);
    endfunction

    logic                 in_acc;
    logic                 s1_adv;
    logic [CTX_AW-1:0]    rd_addr;
    logic [6:0]           ram_rdata;
    logic [6:0]           ctx_word;
    logic                 ctx_we;
    cabac_pkg::item_t     in_item;
    cabac_pkg::upd_t      upd;
    cabac_pkg::coder_t    coder_reg;
    cabac_pkg::coder_t    coder_next;

    logic                 s1_valid_reg;
    cabac_pkg::item_t     s1_item_reg;
    logic [CTX_AW-1:0]    s1_addr_reg;
    logic                 fwd_valid_reg;
    logic [CTX_AW-1:0]    fwd_addr_reg;
    logic [6:0]           fwd_data_reg;
    logic                 out_valid_reg;
    logic                 bin_value_reg;
    logic                 byte_taken_reg;
    logic [5:0]           new_prob_state_reg;
    logic                 new_mps_reg;

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_adv;
    assign in_acc     = item.valid && item.ready;
    assign rd_addr    = ctx_fold(item.ctx_index);

    assign in_item.cmd               = item.cmd;
    assign in_item.stream_byte       = item.stream_byte;
    assign in_item.stream_byte_valid = item.stream_byte_valid;
    assign in_item.load_prob_state   = item.load_prob_state;
    assign in_item.load_mps          = item.load_mps;

    cabac_ram #(
        .WIDTH  (7),
        .DEPTH  (NUM_CONTEXTS),
        .ADDR_W (CTX_AW)
    ) u_ctx_ram (
        .clk   (clk),
        .we    (ctx_we),
        .waddr (s1_addr_reg),
        .wdata ({upd.new_mps, upd.new_prob_state}),
        .re    (in_acc),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // forward the write made in the same cycle as this entry's read
    assign ctx_word = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg
                                                                     : ram_rdata;

    cabac_bin_core u_bin_core (
        .cur      (coder_reg),
        .it       (s1_item_reg),
        .ctx_word (ctx_word),
        .upd      (upd)
    );

    assign ctx_we     = s1_adv && upd.ctx_we;
    assign coder_next = s1_adv ? upd.coder : coder_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coder_reg.coder_range  <= cabac_pkg::RANGE_INIT;
            coder_reg.coder_offset <= '0;
            coder_reg.bits_wanted  <= cabac_pkg::BW_INIT;
            s1_valid_reg           <= 1'b0;
            fwd_valid_reg          <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            coder_reg <= coder_next;
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (ctx_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_item_reg <= in_item;
            s1_addr_reg <= rd_addr;
        end
        if (ctx_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= {upd.new_mps, upd.new_prob_state};
        end
        if (s1_adv)
        begin
            bin_value_reg      <= upd.bin_value;
            byte_taken_reg     <= upd.byte_taken;
            new_prob_state_reg <= upd.new_prob_state;
            new_mps_reg        <= upd.new_mps;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.bin_value      = bin_value_reg;
    assign result.byte_taken     = byte_taken_reg;
    assign result.new_prob_state = new_prob_state_reg;
    assign result.new_mps        = new_mps_reg;

endmodule

`default_nettype wire

// ===== rtl/cabac_checker.sv =====
`default_nettype none

module cabac_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       bin_value,
    input wire logic       byte_taken,
    input wire logic [5:0] new_prob_state,
    input wire logic       new_mps
);

    logic       in_acc;
    logic       out_acc;
    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    assign in_acc       = in_valid && in_ready;
    assign out_acc      = out_valid && out_ready;
    assign pending_next = pending_reg + {2'd0, in_acc} - {2'd0, out_acc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({bin_value, byte_taken, new_prob_state, new_mps}))
        else $error("result word changed while stalled");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more than two words in flight");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result word without an accepted input word");

    a_empty_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && pending_reg == 3'd0 |-> ##2 out_valid)
        else $error("result word late on an empty pipeline");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind cabac_arithmetic_decoder cabac_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (item.valid),
    .in_ready       (item.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .bin_value      (result.bin_value),
    .byte_taken     (result.byte_taken),
    .new_prob_state (result.new_prob_state),
    .new_mps        (result.new_mps)
);

`default_nettype wire

// ===== verif/cabac_arithmetic_decoder_tb.sv =====
`timescale 1ns / 100ps

module cabac_arithmetic_decoder_tb;

    localparam int          CTX_COUNT    = 512;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_WORDS = 100;
    localparam logic [2:0]  CMD_SPARE_LO = 3'd6;
    localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
    localparam logic [31:0] HALF_SCALED  = 32'd32768;

    typedef struct packed {
        logic [2:0] cmd;
        logic [8:0] ctx;
        logic [7:0] data;
        logic       data_ok;
        logic [5:0] ld_prob;
        logic       ld_mps;
    } cmd_word_t;

    typedef struct packed {
        logic       bin_val;
        logic       byte_used;
        logic [5:0] prob;
        logic       mps;
    } bin_word_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE
    } rx_mode_t;

    localparam logic [0:63][0:3][7:0] LPS_RANGE = {
        {8'd128, 8'd176, 8'd208, 8'd240}, {8'd128, 8'd167, 8'd197, 8'd227},
        {8'd128, 8'd158, 8'd187, 8'd216}, {8'd123, 8'd150, 8'd178, 8'd205},
        {8'd116, 8'd142, 8'd169, 8'd195}, {8'd111, 8'd135, 8'd160, 8'd185},
        {8'd105, 8'd128, 8'd152, 8'd175}, {8'd100, 8'd122, 8'd144, 8'd166},
        {8'd95,  8'd116, 8'd137, 8'd158}, {8'd90,  8'd110, 8'd130, 8'd150},
        {8'd85,  8'd104, 8'd123, 8'd142}, {8'd81,  8'd99,  8'd117, 8'd135},
        {8'd77,  8'd94,  8'd111, 8'd128}, {8'd73,  8'd89,  8'd105, 8'd122},
        {8'd69,  8'd85,  8'd100, 8'd116}, {8'd66,  8'd80,  8'd95,  8'd110},
        {8'd62,  8'd76,  8'd90,  8'd104}, {8'd59,  8'd72,  8'd86,  8'd99},
        {8'd56,  8'd69,  8'd81,  8'd94},  {8'd53,  8'd65,  8'd77,  8'd89},
        {8'd51,  8'd62,  8'd73,  8'd85},  {8'd48,  8'd59,  8'd69,  8'd80},
        {8'd46,  8'd56,  8'd66,  8'd76},  {8'd43,  8'd53,  8'd63,  8'd72},
        {8'd41,  8'd50,  8'd59,  8'd69},  {8'd39,  8'd48,  8'd56,  8'd65},
        {8'd37,  8'd45,  8'd54,  8'd62},  {8'd35,  8'd43,  8'd51,  8'd59},
        {8'd33,  8'd41,  8'd48,  8'd56},  {8'd32,  8'd39,  8'd46,  8'd53},
        {8'd30,  8'd37,  8'd43,  8'd50},  {8'd29,  8'd35,  8'd41,  8'd48},
        {8'd27,  8'd33,  8'd39,  8'd45},  {8'd26,  8'd31,  8'd37,  8'd43},
        {8'd24,  8'd30,  8'd35,  8'd41},  {8'd23,  8'd28,  8'd33,  8'd39},
        {8'd22,  8'd27,  8'd32,  8'd37},  {8'd21,  8'd26,  8'd30,  8'd35},
        {8'd20,  8'd24,  8'd29,  8'd33},  {8'd19,  8'd23,  8'd27,  8'd31},
        {8'd18,  8'd22,  8'd26,  8'd30},  {8'd17,  8'd21,  8'd25,  8'd28},
        {8'd16,  8'd20,  8'd23,  8'd27},  {8'd15,  8'd19,  8'd22,  8'd25},
        {8'd14,  8'd18,  8'd21,  8'd24},  {8'd14,  8'd17,  8'd20,  8'd23},
        {8'd13,  8'd16,  8'd19,  8'd22},  {8'd12,  8'd15,  8'd18,  8'd21},
        {8'd12,  8'd14,  8'd17,  8'd20},  {8'd11,  8'd14,  8'd16,  8'd19},
        {8'd11,  8'd13,  8'd15,  8'd18},  {8'd10,  8'd12,  8'd15,  8'd17},
        {8'd10,  8'd12,  8'd14,  8'd16},  {8'd9,   8'd11,  8'd13,  8'd15},
        {8'd9,   8'd11,  8'd12,  8'd14},  {8'd8,   8'd10,  8'd12,  8'd14},
        {8'd8,   8'd9,   8'd11,  8'd13},  {8'd7,   8'd9,   8'd11,  8'd12},
        {8'd7,   8'd9,   8'd10,  8'd12},  {8'd7,   8'd8,   8'd10,  8'd11},
        {8'd6,   8'd8,   8'd9,   8'd11},  {8'd6,   8'd7,   8'd9,   8'd10},
        {8'd6,   8'd7,   8'd8,   8'd9},   {8'd2,   8'd2,   8'd2,   8'd2}
    };

    localparam logic [0:63][5:0] LPS_NEXT = {
        6'd0,  6'd0,  6'd1,  6'd2,  6'd2,  6'd4,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd9,  6'd11, 6'd11, 6'd12,
        6'd13, 6'd13, 6'd15, 6'd15, 6'd16, 6'd16, 6'd18, 6'd18,
        6'd19, 6'd19, 6'd21, 6'd21, 6'd22, 6'd22, 6'd23, 6'd24,
        6'd24, 6'd25, 6'd26, 6'd26, 6'd27, 6'd27, 6'd28, 6'd29,
        6'd29, 6'd30, 6'd30, 6'd30, 6'd31, 6'd32, 6'd32, 6'd33,
        6'd33, 6'd33, 6'd34, 6'd34, 6'd35, 6'd35, 6'd35, 6'd36,
        6'd36, 6'd36, 6'd37, 6'd37, 6'd37, 6'd38, 6'd38, 6'd63
    };

    class bin_tracker;
        logic [8:0]        range_r;
        logic [16:0]       offset_r;
        logic signed [4:0] need_r;
        logic [6:0]        ctx_mem [CTX_COUNT];
        bin_word_t         pending_bins [$];
        int                bad_count;

        function new();
            range_r   = 9'd510;
            offset_r  = '0;
            need_r    = 5'sd8;
            bad_count = 0;
            foreach (ctx_mem[i])
                ctx_mem[i] = '0;
        endfunction

        // double range and offset; refill a byte when the bit count runs out
        function logic renorm_one(cmd_word_t w);
            range_r  = range_r << 1;
            offset_r = offset_r << 1;
            need_r   = need_r + 5'sd1;
            if (need_r == 0)
            begin
                need_r = -5'sd8;
                if (w.data_ok)
                begin
                    offset_r = offset_r | {9'd0, w.data};
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void decode_ahead(cmd_word_t w);
            bin_word_t   r;
            logic [5:0]  st;
            logic        mps;
            logic [7:0]  lps;
            logic [31:0] scaled;
            logic [31:0] wide;
            int          sh;
            r = '0;
            case (w.cmd)
                cabac_pkg::CMD_START_FIRST:
                begin
                    range_r  = 9'd510;
                    offset_r = '0;
                    need_r   = 5'sd8;
                    if (w.data_ok)
                    begin
                        offset_r    = {1'b0, w.data, 8'h00};
                        need_r      = '0;
                        r.byte_used = 1'b1;
                    end
                end
                cabac_pkg::CMD_START_SECOND:
                begin
                    if (w.data_ok)
                    begin
                        offset_r    = offset_r | {9'd0, w.data};
                        need_r      = need_r - 5'sd8;
                        r.byte_used = 1'b1;
                    end
                end
                cabac_pkg::CMD_CTX_BIN:
                begin
                    {mps, st} = ctx_mem[w.ctx];
                    lps       = LPS_RANGE[st][range_r[7:6]];
                    range_r   = range_r - {1'b0, lps};
                    scaled    = {16'd0, range_r, 7'd0};
                    if ({15'd0, offset_r} < scaled)
                    begin
                        r.bin_val = mps;
                        if (st < 6'd62)
                            st = st + 6'd1;
                        if (scaled < HALF_SCALED)
                            r.byte_used = renorm_one(w);
                    end
                    else
                    begin
                        wide     = ({15'd0, offset_r} - scaled);
                        sh       = 0;
                        scaled   = {24'd0, lps};
                        while (scaled < 32'd256 && sh < 8)
                        begin
                            scaled = scaled << 1;
                            sh++;
                        end
                        wide      = wide << sh;
                        offset_r  = wide[16:0];
                        range_r   = scaled[8:0];
                        r.bin_val = ~mps;
                        if (st == 6'd0)
                            mps = ~mps;
                        st     = LPS_NEXT[st];
                        need_r = need_r + 5'(sh);
                        if (need_r >= 0)
                        begin
                            if (w.data_ok)
                            begin
                                wide        = {15'd0, offset_r} | ({24'd0, w.data} << need_r);
                                offset_r    = wide[16:0];
                                r.byte_used = 1'b1;
                            end
                            need_r = need_r - 5'sd8;
                        end
                    end
                    ctx_mem[w.ctx] = {mps, st};
                    r.prob         = st;
                    r.mps          = mps;
                end
                cabac_pkg::CMD_BYPASS:
                begin
                    offset_r = offset_r << 1;
                    need_r   = need_r + 5'sd1;
                    if (need_r >= 0)
                    begin
                        need_r = -5'sd8;
                        if (w.data_ok)
                        begin
                            offset_r    = offset_r | {9'd0, w.data};
                            r.byte_used = 1'b1;
                        end
                    end
                    scaled = {16'd0, range_r, 7'd0};
                    if ({15'd0, offset_r} >= scaled)
                    begin
                        wide      = {15'd0, offset_r} - scaled;
                        offset_r  = wide[16:0];
                        r.bin_val = 1'b1;
                    end
                end
                cabac_pkg::CMD_TERMINATE:
                begin
                    range_r = range_r - 9'd2;
                    scaled  = {16'd0, range_r, 7'd0};
                    if ({15'd0, offset_r} >= scaled)
                        r.bin_val = 1'b1;
                    else if (scaled < HALF_SCALED)
                        r.byte_used = renorm_one(w);
                end
                cabac_pkg::CMD_LOAD_CTX:
                begin
                    ctx_mem[w.ctx] = {w.ld_mps, w.ld_prob};
                    r.prob         = w.ld_prob;
                    r.mps          = w.ld_mps;
                end
                default:
                begin
                end
            endcase
            pending_bins.push_back(r);
        endfunction

        function void report(string what, logic [7:0] want, logic [7:0] got);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            bad_count++;
        endfunction

        function void compare_bin(bin_word_t got);
            bin_word_t want;
            if (pending_bins.size() == 0)
            begin
                $display("%0t: result word with nothing pending, expected none, actual %h",
                         $time, got);
                bad_count++;
                return;
            end
            want = pending_bins.pop_front();
            if (got.bin_val !== want.bin_val)
                report("bin_value", want.bin_val, got.bin_val);
            if (got.byte_used !== want.byte_used)
                report("byte_taken", want.byte_used, got.byte_used);
            if (got.prob !== want.prob)
                report("new_prob_state", want.prob, got.prob);
            if (got.mps !== want.mps)
                report("new_mps", want.mps, got.mps);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cabac_item_if   item_ch ();
    cabac_result_if res_ch ();

    cabac_arithmetic_decoder #(
        .NUM_CONTEXTS(CTX_COUNT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .result(res_ch)
    );

    bin_tracker tracker = new();

    int         burst_left;
    int         words_sent;
    int         cycle_cnt;
    int         ready_hold;
    int         ready_phase;
    rx_mode_t   ready_mode;
    bit         ctx_loaded [CTX_COUNT];
    logic [8:0] loaded_list [$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        item_ch.valid             = 1'b0;
        item_ch.cmd               = '0;
        item_ch.ctx_index         = '0;
        item_ch.stream_byte       = '0;
        item_ch.stream_byte_valid = 1'b0;
        item_ch.load_prob_state   = '0;
        item_ch.load_mps          = 1'b0;
        res_ch.ready              = 1'b0;
        burst_left                = 0;
        ready_hold                = 0;
        ready_phase               = 0;
        ready_mode                = RX_OPEN;
        cycle_cnt                 = 0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                tracker.decode_ahead(cmd_word_t'({item_ch.cmd, item_ch.ctx_index,
                    item_ch.stream_byte, item_ch.stream_byte_valid,
                    item_ch.load_prob_state, item_ch.load_mps}));
            if (res_ch.valid && res_ch.ready)
                tracker.compare_bin(bin_word_t'({res_ch.bin_value, res_ch.byte_taken,
                    res_ch.new_prob_state, res_ch.new_mps}));
        end
    end

    always @(negedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_mode = rx_mode_t'($urandom_range(0, 2));
            ready_hold = $urandom_range(16, 96);
        end
        ready_hold--;
        ready_phase++;
        case (ready_mode)
            RX_OPEN:   res_ch.ready <= 1'b1;
            RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
            default:   res_ch.ready <= (ready_phase % 4 == 0);
        endcase
    end

    task automatic send_word(input cmd_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                @(negedge clk);
                item_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(32, 64)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        item_ch.valid             <= 1'b1;
        item_ch.cmd               <= w.cmd;
        item_ch.ctx_index         <= w.ctx;
        item_ch.stream_byte       <= w.data;
        item_ch.stream_byte_valid <= w.data_ok;
        item_ch.load_prob_state   <= w.ld_prob;
        item_ch.load_mps          <= w.ld_mps;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    task automatic issue(input logic [2:0] cmd, input logic [8:0] ctx, input logic [7:0] data,
                         input logic data_ok, input logic [5:0] prob, input logic mps);
        if (cmd == cabac_pkg::CMD_LOAD_CTX && !ctx_loaded[ctx])
        begin
            ctx_loaded[ctx] = 1'b1;
            loaded_list.push_back(ctx);
        end
        send_word('{cmd, ctx, data, data_ok, prob, mps});
        words_sent++;
    endtask

    // favor a few hot contexts so back-to-back bins hit the same entry
    function automatic logic [8:0] pick_ctx();
        int span;
        span = loaded_list.size();
        if ($urandom_range(0, 3) != 0 && span > 8)
            span = 8;
        return loaded_list[$urandom_range(0, span - 1)];
    endfunction

    task automatic issue_random(input logic [2:0] cmd);
        logic [8:0] ctx;
        ctx = 9'($urandom_range(0, CTX_COUNT - 1));
        if (cmd == cabac_pkg::CMD_CTX_BIN
            || (cmd == cabac_pkg::CMD_LOAD_CTX && $urandom_range(0, 1) == 0))
            ctx = pick_ctx();
        issue(cmd, ctx, 8'($urandom_range(0, 255)), ($urandom_range(0, 15) != 0),
              6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    endtask

    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending_bins.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int pick;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        issue(cabac_pkg::CMD_LOAD_CTX, 9'd0, 8'h00, 1'b0, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_LOAD_CTX, 9'd511, 8'hFF, 1'b1, 6'd63, 1'b1);
        issue(cabac_pkg::CMD_LOAD_CTX, 9'd1, 8'h5A, 1'b1, 6'd62, 1'b1);
        issue(cabac_pkg::CMD_LOAD_CTX, 9'd2, 8'hA5, 1'b0, 6'd0, 1'b1);
        issue(cabac_pkg::CMD_LOAD_CTX, 9'h155, 8'h3C, 1'b1, 6'd42, 1'b0);
        // missing bytes
        issue(cabac_pkg::CMD_START_FIRST, 9'h0AA, 8'hFF, 1'b0, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_START_SECOND, 9'd0, 8'hFF, 1'b0, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_CTX_BIN, 9'd0, 8'hFF, 1'b0, 6'd0, 1'b0);
        // offset at its top: terminate ends, LPS paths taken
        issue(cabac_pkg::CMD_START_FIRST, 9'd0, 8'hFF, 1'b1, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_START_SECOND, 9'd0, 8'hFF, 1'b1, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_TERMINATE, 9'd0, 8'h81, 1'b1, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_CTX_BIN, 9'd2, 8'h7E, 1'b1, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_CTX_BIN, 9'd511, 8'hC3, 1'b1, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_START_FIRST, 9'd0, 8'h00, 1'b1, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_START_SECOND, 9'd0, 8'h00, 1'b1, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_CTX_BIN, 9'd0, 8'hFF, 1'b1, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_CTX_BIN, 9'd0, 8'h01, 1'b1, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_CTX_BIN, 9'd1, 8'h80, 1'b1, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_BYPASS, 9'd0, 8'hFF, 1'b1, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_BYPASS, 9'd0, 8'h00, 1'b0, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_TERMINATE, 9'd0, 8'h55, 1'b1, 6'd0, 1'b0);
        issue(CMD_SPARE_LO, 9'd511, 8'hFF, 1'b1, 6'd63, 1'b1);
        issue(CMD_SPARE_HI, 9'd0, 8'h00, 1'b0, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_START_FIRST, 9'd0, 8'hAA, 1'b1, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_START_SECOND, 9'd0, 8'h55, 1'b0, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_BYPASS, 9'd0, 8'h33, 1'b1, 6'd0, 1'b0);
        settle();

        // walk the range below 256 with terminate ends, drop it to 256 through a
        // state-63 bin, then keep terminating through its wrap
        issue(cabac_pkg::CMD_START_FIRST, 9'd0, 8'hFF, 1'b1, 6'd0, 1'b0);
        issue(cabac_pkg::CMD_START_SECOND, 9'd0, 8'hFF, 1'b1, 6'd0, 1'b0);
        repeat (140) issue_random(cabac_pkg::CMD_TERMINATE);
        issue_random(cabac_pkg::CMD_BYPASS);
        issue(cabac_pkg::CMD_CTX_BIN, 9'd511, 8'h96, 1'b1, 6'd0, 1'b0);
        repeat (130) issue_random(cabac_pkg::CMD_TERMINATE);
        issue_random(cabac_pkg::CMD_CTX_BIN);
        settle();

        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6)) issue_random(3'($urandom_range(0, 7)));
            end
            else
            begin
                issue_random(cabac_pkg::CMD_START_FIRST);
                issue_random(cabac_pkg::CMD_START_SECOND);
                repeat ($urandom_range(4, 40))
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)
                        issue_random(cabac_pkg::CMD_CTX_BIN);
                    else if (pick < 75)
                        issue_random(cabac_pkg::CMD_BYPASS);
                    else if (pick < 87)
                        issue_random(cabac_pkg::CMD_TERMINATE);
                    else
                        issue_random(cabac_pkg::CMD_LOAD_CTX);
                end
            end
            if ($urandom_range(0, 11) == 0)
                settle();
        end

        settle();
        repeat (8) @(posedge clk);
        if (tracker.bad_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
